// ===== hw/rtl/lfpd_pkg.sv =====
// Shared constants for the line follower PID drive block.
package lfpd_pkg;

   localparam int GAIN_WIDTH      = 16;
   localparam int SPEED_WIDTH     = 8;
   localparam int ERROR_WIDTH     = 3;
   localparam int DIFF_WIDTH      = ERROR_WIDTH + 1;
   localparam int FRAC_BITS       = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = GAIN_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASE_SPEED = 2'd3;

   localparam logic signed [GAIN_WIDTH-1:0] GAIN_P_RESET     = 16'sd256;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_I_RESET     = 16'sd0;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_D_RESET     = 16'sd0;
   localparam logic        [SPEED_WIDTH-1:0] BASE_SPEED_RESET = 8'd155;
   localparam logic        [SPEED_WIDTH-1:0] DUTY_MAX         = 8'd255;

endpackage

// ===== hw/rtl/lfpd_front.sv =====
// Sensor decode, saturating integral and previous error, first pipeline register.
module lfpd_front import lfpd_pkg::*; #(
   parameter int INTEGRAL_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_sense_left,
   input  logic                             req_sense_middle,
   input  logic                             req_sense_right,
   output logic                             s1_valid,
   input  logic                             s1_ready,
   output logic signed [ERROR_WIDTH-1:0]    s1_error,
   output logic signed [DIFF_WIDTH-1:0]     s1_diff,
   output logic signed [INTEGRAL_WIDTH-1:0] s1_sum
);

   function automatic logic signed [ERROR_WIDTH-1:0] decode_error(
      input logic l, input logic m, input logic r);
      logic signed [ERROR_WIDTH-1:0] mag;
      mag = m ? ERROR_WIDTH'(1) : ERROR_WIDTH'(2);
      if (l && !r) begin
         return -mag;
      end else if (!l && r) begin
         return mag;
      end
      return '0;
   endfunction

   logic signed [INTEGRAL_WIDTH-1:0] error_sum_ff, error_sum_in;
   logic signed [ERROR_WIDTH-1:0]    prev_error_ff;
   logic                             valid_ff;
   logic signed [ERROR_WIDTH-1:0]    error_ff, error_in;
   logic signed [DIFF_WIDTH-1:0]     diff_ff, diff_in;
   logic signed [INTEGRAL_WIDTH-1:0] sum_ff;
   logic signed [INTEGRAL_WIDTH:0]   sum_wide;
   logic                             accept;

   assign req_ready = !valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      error_in = decode_error(req_sense_left, req_sense_middle, req_sense_right);
      diff_in  = DIFF_WIDTH'(error_in) - DIFF_WIDTH'(prev_error_ff);
      sum_wide = (INTEGRAL_WIDTH+1)'(error_sum_ff) + (INTEGRAL_WIDTH+1)'(error_in);
      if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1]) begin
         error_sum_in = sum_wide[INTEGRAL_WIDTH] ?
                        {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}} :
                        {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end else begin
         error_sum_in = sum_wide[INTEGRAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            error_sum_ff  <= error_sum_in;
            prev_error_ff <= error_in;
         end
         if (req_ready) begin
            valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         error_ff <= error_in;
         diff_ff  <= diff_in;
         sum_ff   <= error_sum_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_error = error_ff;
   assign s1_diff  = diff_ff;
   assign s1_sum   = sum_ff;

endmodule

// ===== hw/rtl/lfpd_mult.sv =====
// Gain products, registered.
module lfpd_mult import lfpd_pkg::*; #(
   parameter int INTEGRAL_WIDTH = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [GAIN_WIDTH-1:0]            gain_p,
   input  logic signed [GAIN_WIDTH-1:0]            gain_i,
   input  logic signed [GAIN_WIDTH-1:0]            gain_d,
   input  logic                                    s1_valid,
   output logic                                    s1_ready,
   input  logic signed [ERROR_WIDTH-1:0]           s1_error,
   input  logic signed [DIFF_WIDTH-1:0]            s1_diff,
   input  logic signed [INTEGRAL_WIDTH-1:0]        s1_sum,
   output logic                                    s2_valid,
   input  logic                                    s2_ready,
   output logic signed [ERROR_WIDTH-1:0]           s2_error,
   output logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0] s2_p_prod,
   output logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] s2_i_prod,
   output logic signed [GAIN_WIDTH+DIFF_WIDTH-1:0] s2_d_prod
);

   logic                                        valid_ff;
   logic                                        accept;
   logic signed [ERROR_WIDTH-1:0]               error_ff;
   logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0]    p_prod_ff, p_prod_in;
   logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] i_prod_ff, i_prod_in;
   logic signed [GAIN_WIDTH+DIFF_WIDTH-1:0]     d_prod_ff, d_prod_in;

   assign s1_ready = !valid_ff || s2_ready;
   assign accept   = s1_valid && s1_ready;

   always_comb begin
      p_prod_in = (GAIN_WIDTH+ERROR_WIDTH)'(gain_p) * (GAIN_WIDTH+ERROR_WIDTH)'(s1_error);
      i_prod_in = (GAIN_WIDTH+INTEGRAL_WIDTH)'(gain_i) *
                  (GAIN_WIDTH+INTEGRAL_WIDTH)'(s1_sum);
      d_prod_in = (GAIN_WIDTH+DIFF_WIDTH)'(gain_d) * (GAIN_WIDTH+DIFF_WIDTH)'(s1_diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s1_ready) begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         error_ff  <= s1_error;
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
   end

   assign s2_valid  = valid_ff;
   assign s2_error  = error_ff;
   assign s2_p_prod = p_prod_ff;
   assign s2_i_prod = i_prod_ff;
   assign s2_d_prod = d_prod_ff;

endmodule

// ===== hw/rtl/lfpd_mix.sv =====
// PID sum, duty mixing and clamping, result register.
module lfpd_mix import lfpd_pkg::*; #(
   parameter int INTEGRAL_WIDTH = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [SPEED_WIDTH-1:0]                      base_speed,
   input  logic                                        s2_valid,
   output logic                                        s2_ready,
   input  logic signed [ERROR_WIDTH-1:0]               s2_error,
   input  logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0]    s2_p_prod,
   input  logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] s2_i_prod,
   input  logic signed [GAIN_WIDTH+DIFF_WIDTH-1:0]     s2_d_prod,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [SPEED_WIDTH-1:0]                      rsp_left_duty,
   output logic [SPEED_WIDTH-1:0]                      rsp_right_duty,
   output logic                                        rsp_left_forward,
   output logic                                        rsp_right_forward,
   output logic signed [ERROR_WIDTH-1:0]               rsp_line_error
);

   localparam int PidWidth  = INTEGRAL_WIDTH + GAIN_WIDTH + 2;
   localparam int DutyWidth = PidWidth + 2;

   function automatic logic [SPEED_WIDTH-1:0] clamp_duty(
      input logic signed [DutyWidth-1:0] q);
      if (q[DutyWidth-1]) begin
         return '0;
      end else if (|q[DutyWidth-2:FRAC_BITS+SPEED_WIDTH]) begin
         return DUTY_MAX;
      end
      return q[FRAC_BITS+SPEED_WIDTH-1:FRAC_BITS];
   endfunction

   logic signed [PidWidth-1:0]  pid;
   logic                        pid_neg;
   logic                        pid_zero;
   logic [PidWidth-1:0]         mag;
   logic signed [DutyWidth-1:0] base_q;
   logic signed [DutyWidth-1:0] up_q, down_q;
   logic                        valid_ff;
   logic                        accept;
   logic [SPEED_WIDTH-1:0]      left_duty_ff, left_duty_in;
   logic [SPEED_WIDTH-1:0]      right_duty_ff, right_duty_in;
   logic                        left_fwd_ff, right_fwd_ff;
   logic signed [ERROR_WIDTH-1:0] error_ff;

   assign s2_ready = !valid_ff || rsp_ready;
   assign accept   = s2_valid && s2_ready;

   always_comb begin
      pid      = PidWidth'(s2_p_prod) + PidWidth'(s2_i_prod) + PidWidth'(s2_d_prod);
      pid_neg  = pid[PidWidth-1];
      pid_zero = (pid == '0);
      mag      = pid_neg ? PidWidth'(-pid) : PidWidth'(pid);
      base_q   = DutyWidth'({base_speed, {FRAC_BITS{1'b0}}});
      up_q     = base_q + DutyWidth'(mag);
      down_q   = base_q - DutyWidth'(mag);
      if (pid_neg) begin
         left_duty_in  = clamp_duty(down_q);
         right_duty_in = clamp_duty(up_q);
      end else begin
         left_duty_in  = clamp_duty(up_q);
         right_duty_in = clamp_duty(down_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s2_ready) begin
         valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         left_fwd_ff   <= !pid_neg;
         right_fwd_ff  <= pid_neg || pid_zero;
         error_ff      <= s2_error;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_left_duty     = left_duty_ff;
   assign rsp_right_duty    = right_duty_ff;
   assign rsp_left_forward  = left_fwd_ff;
   assign rsp_right_forward = right_fwd_ff;
   assign rsp_line_error    = error_ff;

endmodule

// ===== hw/rtl/line_follow_pid_drive.sv =====
// Line follower PID drive: top level with control registers and pipeline.
//
// Usage: one transaction on the req_ channel carries a sample of the three
// line sensors; each yields exactly one transaction on the rsp_ channel with
// both PWM duties, both direction bits and the decoded line error.
// Both channels use valid/ready; a transaction moves when both are high.
// Pipeline: decode and integral update, gain multiplies, PID mix and clamp,
// each closed by a register; a req_ transaction passes these three registers
// in order before rsp_valid. Throughput is one transaction per cycle while
// rsp_ready holds high; each register stage advances when the next is ready.
// The integral and previous error update at req_ acceptance, in order.
// A stalled rsp_ready holds the result; the stages behind it fill, and
// req_ready drops once all three hold a transaction.
// The csr_ port writes gains (signed Q8.8) and base speed at csr_write_en;
// write only while no transaction is in flight.
// Reset clears the integral, previous error and pipeline, and loads gain_p
// 1.0, gain_i 0, gain_d 0 and base speed 155.
module line_follow_pid_drive import lfpd_pkg::*; #(
   parameter int INTEGRAL_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_sense_left,
   input  logic                          req_sense_middle,
   input  logic                          req_sense_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SPEED_WIDTH-1:0]        rsp_left_duty,
   output logic [SPEED_WIDTH-1:0]        rsp_right_duty,
   output logic                          rsp_left_forward,
   output logic                          rsp_right_forward,
   output logic signed [ERROR_WIDTH-1:0] rsp_line_error
);

   logic signed [GAIN_WIDTH-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SPEED_WIDTH-1:0]       base_speed_ff;

   logic                                        s1_valid, s1_ready;
   logic signed [ERROR_WIDTH-1:0]               s1_error;
   logic signed [DIFF_WIDTH-1:0]                s1_diff;
   logic signed [INTEGRAL_WIDTH-1:0]            s1_sum;
   logic                                        s2_valid, s2_ready;
   logic signed [ERROR_WIDTH-1:0]               s2_error;
   logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0]    s2_p_prod;
   logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] s2_i_prod;
   logic signed [GAIN_WIDTH+DIFF_WIDTH-1:0]     s2_d_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         base_speed_ff <= BASE_SPEED_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_GAIN_P:     gain_p_ff     <= csr_wdata;
            REG_GAIN_I:     gain_i_ff     <= csr_wdata;
            REG_GAIN_D:     gain_d_ff     <= csr_wdata;
            REG_BASE_SPEED: base_speed_ff <= csr_wdata[SPEED_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   lfpd_front #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sense_left   (req_sense_left),
      .req_sense_middle (req_sense_middle),
      .req_sense_right  (req_sense_right),
      .s1_valid         (s1_valid),
      .s1_ready         (s1_ready),
      .s1_error         (s1_error),
      .s1_diff          (s1_diff),
      .s1_sum           (s1_sum)
   );

   lfpd_mult #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_error  (s1_error),
      .s1_diff   (s1_diff),
      .s1_sum    (s1_sum),
      .s2_valid  (s2_valid),
      .s2_ready  (s2_ready),
      .s2_error  (s2_error),
      .s2_p_prod (s2_p_prod),
      .s2_i_prod (s2_i_prod),
      .s2_d_prod (s2_d_prod)
   );

   lfpd_mix #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mix (
      .clock             (clock),
      .reset             (reset),
      .base_speed        (base_speed_ff),
      .s2_valid          (s2_valid),
      .s2_ready          (s2_ready),
      .s2_error          (s2_error),
      .s2_p_prod         (s2_p_prod),
      .s2_i_prod         (s2_i_prod),
      .s2_d_prod         (s2_d_prod),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward),
      .rsp_line_error    (rsp_line_error)
   );

endmodule
